// ===== hdl/mmt_pkg.sv =====
// shared types and constants for the message match table
`default_nettype none
package mmt_pkg;
    localparam int ENTRIES_DEF  = 16;
    localparam int FRAG_BYTES_DEF = 4096;
    localparam logic [23:0] MASK24 = 24'hFFFFFF;

    typedef enum logic [2:0] {
        MODE_PUSH   = 3'd0,
        MODE_POST   = 3'd1,
        MODE_POP    = 3'd2,
        MODE_PROBE  = 3'd3,
        MODE_REMOVE = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_TOO_SMALL  = 3'd2,
        ST_FULL       = 3'd3,
        ST_INCOMPLETE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
    } t_cmd;
endpackage
`default_nettype wire

// ===== hdl/mmt_ctrl.sv =====
// controller: sequences lookup and update cycles
`default_nettype none
module mmt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output mmt_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import mmt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/mmt_datapath.sv =====
// datapath: entry registers, parallel match, age-ordered select and update
`default_nettype none
module mmt_datapath #(
    parameter int ENTRIES    = mmt_pkg::ENTRIES_DEF,
    parameter int FRAG_BYTES = mmt_pkg::FRAG_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mmt_pkg::t_cmd      i_cmd,
    input  wire logic [2:0]    i_mode,
    input  wire logic [9:0]    i_source,
    input  wire logic          i_source_any,
    input  wire logic [15:0]   i_tag,
    input  wire logic          i_tag_any,
    input  wire logic [12:0]   i_fragment_size,
    input  wire logic [23:0]   i_total_size,
    input  wire logic [11:0]   i_part,
    input  wire logic [23:0]   i_buffer_size,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [3:0]         o_slot,
    output logic [23:0]        o_write_offset,
    output logic [23:0]        o_copy_length,
    output logic               o_user_buffer_held,
    output logic [9:0]         o_match_source,
    output logic               o_match_source_any,
    output logic [15:0]        o_match_tag,
    output logic               o_match_tag_any,
    output logic [23:0]        o_message_size,
    output logic [23:0]        o_received_size,
    output logic [$clog2(ENTRIES+1)-1:0] o_count
);
    import mmt_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int FB = $clog2(FRAG_BYTES);

    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_rank [ENTRIES];
    logic [9:0]         r_src  [ENTRIES];
    logic               r_sany [ENTRIES];
    logic [15:0]        r_tag  [ENTRIES];
    logic               r_tany [ENTRIES];
    logic [23:0]        r_tot  [ENTRIES];
    logic [23:0]        r_rcv  [ENTRIES];
    logic               r_ubuf [ENTRIES];
    logic [CW-1:0]      r_count;

    // captured request
    logic [2:0]  r_mode;
    logic [9:0]  r_isrc;
    logic        r_isany;
    logic [15:0] r_itag;
    logic        r_itany;
    logic [12:0] r_frag;
    logic [23:0] r_itot;
    logic [11:0] r_part;
    logic [23:0] r_buf;

    // lookup results registered in the capture cycle
    logic          r_hit;
    logic [IW-1:0] r_sel;
    logic          r_free_ok;
    logic [IW-1:0] r_free;

    // per-entry match vectors
    logic [ENTRIES-1:0] match_any, match_inc;
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_any[i] = r_valid[i]
                && (i_source_any || r_sany[i] || r_src[i] == i_source)
                && (i_tag_any || r_tany[i] || r_tag[i] == i_tag);
            match_inc[i] = match_any[i] && (r_rcv[i] < r_tot[i]);
        end
    end

    // oldest match: ranks are unique among valid entries, so pick the one whose
    // rank has no smaller matching rank
    logic [ENTRIES-1:0] cand;
    logic               hit;
    logic [IW-1:0]      sel;
    logic               free_ok;
    logic [IW-1:0]      free_idx;
    always_comb begin
        cand = (i_mode == MODE_PUSH) ? match_inc : match_any;
        hit  = |cand;
        sel  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            logic older;
            older = 1'b0;
            for (int j = 0; j < ENTRIES; j++) begin
                if (cand[j] && r_rank[j] < r_rank[i]) older = 1'b1;
            end
            if (cand[i] && !older) sel = IW'(i);
        end
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
        if (r_count >= CW'(ENTRIES)) free_ok = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_isrc  <= i_source;
            r_isany <= i_source_any;
            r_itag  <= i_tag;
            r_itany <= i_tag_any;
            r_frag  <= i_fragment_size;
            r_itot  <= i_total_size;
            r_part  <= i_part;
            r_buf   <= i_buffer_size;
            r_hit   <= hit;
            r_sel   <= sel;
            r_free_ok <= free_ok;
            r_free  <= free_idx;
        end
    end

    // selected entry fields before update
    logic [9:0]  e_src;
    logic        e_sany;
    logic [15:0] e_tag;
    logic        e_tany;
    logic [23:0] e_tot;
    logic [23:0] e_rcv;
    logic        e_ubuf;
    logic [IW-1:0] e_rank;
    assign e_src  = r_src[r_sel];
    assign e_sany = r_sany[r_sel];
    assign e_tag  = r_tag[r_sel];
    assign e_tany = r_tany[r_sel];
    assign e_tot  = r_tot[r_sel];
    assign e_rcv  = r_rcv[r_sel];
    assign e_ubuf = r_ubuf[r_sel];
    assign e_rank = r_rank[r_sel];

    logic [24:0] sum;
    logic [23:0] sum_sat;
    logic [FB+12:0] off_full;
    logic [23:0] off_sat;
    assign sum      = {1'b0, e_rcv} + {12'd0, r_frag};
    assign sum_sat  = sum[24] ? MASK24 : sum[23:0];
    assign off_full = {1'b0, r_part, FB'(0)};
    assign off_sat  = (off_full > (FB+13)'(MASK24)) ? MASK24 : 24'(off_full);

    // result and update decisions
    logic        do_ins, do_upd_push, do_upd_post, do_rm;
    logic [IW-1:0] slot_idx;
    logic [2:0]  n_status;
    logic [23:0] n_woff, n_copy, n_msize, n_rsize;
    logic        n_held, n_msany, n_mtany, show;
    logic [9:0]  n_msrc;
    logic [15:0] n_mtag;
    always_comb begin
        do_ins = 1'b0; do_upd_push = 1'b0; do_upd_post = 1'b0; do_rm = 1'b0;
        slot_idx = r_sel;
        n_status = ST_NOT_FOUND;
        n_woff = '0; n_copy = '0; n_held = 1'b0; show = 1'b0;
        n_msrc = e_src; n_msany = e_sany; n_mtag = e_tag; n_mtany = e_tany;
        n_msize = e_tot; n_rsize = e_rcv;
        case (r_mode)
            MODE_PUSH, MODE_POST: begin
                if (r_hit) begin
                    show = 1'b1;
                    n_status = ST_OK;
                    n_held = e_ubuf;
                    if (r_mode == MODE_PUSH) begin
                        do_upd_push = 1'b1;
                        n_msrc = r_isrc; n_msany = r_isany;
                        n_mtag = r_itag; n_mtany = r_itany;
                        n_msize = r_itot; n_rsize = sum_sat;
                    end else begin
                        do_upd_post = 1'b1;
                        n_copy = e_rcv;
                    end
                end else if (r_free_ok) begin
                    show = 1'b1;
                    do_ins = 1'b1;
                    slot_idx = r_free;
                    n_status = ST_OK;
                    n_msrc = r_isrc; n_msany = r_isany;
                    n_mtag = r_itag; n_mtany = r_itany;
                    n_msize = r_itot;
                    n_rsize = (r_mode == MODE_PUSH) ? {11'd0, r_frag} : '0;
                end else begin
                    n_status = ST_FULL;
                end
                if (show && r_mode == MODE_PUSH) begin
                    n_woff = off_sat;
                    n_copy = {11'd0, r_frag};
                end
            end
            MODE_POP: begin
                if (r_hit) begin
                    show = 1'b1; do_rm = 1'b1; n_held = e_ubuf;
                    if (r_buf < e_tot) begin
                        n_status = ST_TOO_SMALL;
                        n_rsize = '0;
                    end else begin
                        n_status = ST_OK;
                        n_copy = e_ubuf ? '0 : e_rcv;
                    end
                end
            end
            MODE_PROBE: begin
                if (r_hit) begin
                    show = 1'b1; n_held = e_ubuf;
                    n_status = (e_rcv < e_tot) ? ST_INCOMPLETE : ST_OK;
                end
            end
            MODE_REMOVE: begin
                if (r_hit) begin
                    show = 1'b1; do_rm = 1'b1; n_held = e_ubuf;
                    n_status = ST_OK;
                end
            end
            default: ;
        endcase
    end

    // table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.update) begin
            if (do_ins) begin
                r_valid[slot_idx] <= 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (do_rm) begin
                r_valid[r_sel] <= 1'b0;
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (do_rm && r_valid[i] && r_rank[i] > e_rank) r_rank[i] <= r_rank[i] - 1'b1;
            end
            if (do_ins) begin
                r_rank[slot_idx] <= r_count[IW-1:0];
                r_ubuf[slot_idx] <= (r_mode == MODE_POST);
            end
            if (do_ins || do_upd_push) begin
                r_src[slot_idx]  <= r_isrc;
                r_sany[slot_idx] <= r_isany;
                r_tag[slot_idx]  <= r_itag;
                r_tany[slot_idx] <= r_itany;
                r_tot[slot_idx]  <= r_itot;
                r_rcv[slot_idx]  <= n_rsize;
            end
            if (do_upd_post) r_ubuf[slot_idx] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_status           <= n_status;
            o_slot             <= show ? 4'(slot_idx) : 4'd0;
            o_write_offset     <= n_woff;
            o_copy_length      <= n_copy;
            o_user_buffer_held <= n_held;
            o_match_source     <= show ? n_msrc : '0;
            o_match_source_any <= show & n_msany;
            o_match_tag        <= show ? n_mtag : '0;
            o_match_tag_any    <= show & n_mtany;
            o_message_size     <= show ? n_msize : '0;
            o_received_size    <= show ? n_rsize : '0;
        end
    end

    assign o_count = r_count;
endmodule
`default_nettype wire

// ===== hdl/message_match_table.sv =====
// top level of the message match table
// steps: request and lookup capture, table update, then the registered result beat
// busy holds off a new item until the table update of the last one is done
// the lookup is a parallel compare over all entries with oldest-first priority
// reset (synchronous, active low) empties the table; no clearing pass is needed
// results are shown for one cycle; the receiver cannot stall
`default_nettype none
module message_match_table #(
    parameter int ENTRIES    = mmt_pkg::ENTRIES_DEF,
    parameter int FRAG_BYTES = mmt_pkg::FRAG_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [9:0]  i_source,
    input  wire logic        i_source_any,
    input  wire logic [15:0] i_tag,
    input  wire logic        i_tag_any,
    input  wire logic [12:0] i_fragment_size,
    input  wire logic [23:0] i_total_size,
    input  wire logic [11:0] i_part,
    input  wire logic [23:0] i_buffer_size,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [3:0]       o_slot,
    output logic [23:0]      o_write_offset,
    output logic [23:0]      o_copy_length,
    output logic             o_user_buffer_held,
    output logic [9:0]       o_match_source,
    output logic             o_match_source_any,
    output logic [15:0]      o_match_tag,
    output logic             o_match_tag_any,
    output logic [23:0]      o_message_size,
    output logic [23:0]      o_received_size
);
    import mmt_pkg::*;

    t_cmd cmd;
    logic [$clog2(ENTRIES+1)-1:0] count;

    mmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mmt_datapath #(.ENTRIES(ENTRIES), .FRAG_BYTES(FRAG_BYTES)) u_dp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_cmd (cmd),
        .i_mode (i_mode), .i_source (i_source), .i_source_any (i_source_any),
        .i_tag (i_tag), .i_tag_any (i_tag_any), .i_fragment_size (i_fragment_size),
        .i_total_size (i_total_size), .i_part (i_part), .i_buffer_size (i_buffer_size),
        .o_valid (o_valid), .o_status (o_status), .o_slot (o_slot),
        .o_write_offset (o_write_offset), .o_copy_length (o_copy_length),
        .o_user_buffer_held (o_user_buffer_held), .o_match_source (o_match_source),
        .o_match_source_any (o_match_source_any), .o_match_tag (o_match_tag),
        .o_match_tag_any (o_match_tag_any), .o_message_size (o_message_size),
        .o_received_size (o_received_size), .o_count (count)
    );

    // every accepted beat produces its result strobe after the table update
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result strobe missing");

    // result strobe only at the end of an item
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("strobe without work");

    // fill count never exceeds the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= ($clog2(ENTRIES+1))'(ENTRIES))
        else $error("entry count overflow");
endmodule
`default_nettype wire

// ===== tb/message_match_table_tb.sv =====
// self-checking testbench for the message match table
`default_nettype none
module message_match_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mmt_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [9:0]  source;
        logic        source_any;
        logic [15:0] tag;
        logic        tag_any;
        logic [12:0] fragment_size;
        logic [23:0] total_size;
        logic [11:0] part;
        logic [23:0] buffer_size;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [23:0] write_offset;
        logic [23:0] copy_length;
        logic        user_buffer_held;
        logic [9:0]  match_source;
        logic        match_source_any;
        logic [15:0] match_tag;
        logic        match_tag_any;
        logic [23:0] message_size;
        logic [23:0] received_size;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_request req_q = '0;
    logic o_valid;
    t_reply got;

    message_match_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(req_q.mode), .i_source(req_q.source), .i_source_any(req_q.source_any),
        .i_tag(req_q.tag), .i_tag_any(req_q.tag_any),
        .i_fragment_size(req_q.fragment_size), .i_total_size(req_q.total_size),
        .i_part(req_q.part), .i_buffer_size(req_q.buffer_size),
        .o_valid(o_valid), .o_status(got.status), .o_slot(got.slot),
        .o_write_offset(got.write_offset), .o_copy_length(got.copy_length),
        .o_user_buffer_held(got.user_buffer_held), .o_match_source(got.match_source),
        .o_match_source_any(got.match_source_any), .o_match_tag(got.match_tag),
        .o_match_tag_any(got.match_tag_any), .o_message_size(got.message_size),
        .o_received_size(got.received_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table mirror
    logic        tb_valid [NSLOT];
    int unsigned tb_rank  [NSLOT];
    logic [9:0]  tb_src   [NSLOT];
    logic        tb_sany  [NSLOT];
    logic [15:0] tb_tag   [NSLOT];
    logic        tb_tany  [NSLOT];
    logic [23:0] tb_total [NSLOT];
    logic [23:0] tb_recv  [NSLOT];
    logic        tb_user  [NSLOT];
    int unsigned tb_count;

    t_request pending_items[$];
    t_reply   expected_replies[$];
    int  send_idle_pct = 0;
    bit  hold_off = 0;
    bit  failed = 0;
    int  quiet_cycles = 0;

    function automatic void add_item(t_request r);
        pending_items.insert(pending_items.size(), r);
    endfunction

    function automatic int oldest_match(t_request r, bit only_incomplete);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (!tb_valid[i]) continue;
            if (!(r.source_any || tb_sany[i] || tb_src[i] == r.source)) continue;
            if (!(r.tag_any || tb_tany[i] || tb_tag[i] == r.tag)) continue;
            if (only_incomplete && tb_recv[i] >= tb_total[i]) continue;
            if (best < 0 || tb_rank[i] < tb_rank[best]) best = i;
        end
        return best;
    endfunction

    function automatic int free_entry();
        if (tb_count >= NSLOT) return -1;
        for (int i = 0; i < NSLOT; i++) if (!tb_valid[i]) return i;
        return -1;
    endfunction

    function automatic void store_entry(int s, t_request r, logic [23:0] recv, logic user);
        tb_valid[s] = 1; tb_rank[s] = tb_count;
        tb_src[s] = r.source; tb_sany[s] = r.source_any;
        tb_tag[s] = r.tag; tb_tany[s] = r.tag_any;
        tb_total[s] = r.total_size; tb_recv[s] = recv; tb_user[s] = user;
        tb_count++;
    endfunction

    function automatic void drop_entry(int s);
        tb_valid[s] = 0;
        for (int i = 0; i < NSLOT; i++)
            if (tb_valid[i] && tb_rank[i] > tb_rank[s]) tb_rank[i]--;
        if (tb_count > 0) tb_count--;
    endfunction

    function automatic void fill_match(ref t_reply e, input int s);
        e.slot = s[3:0];
        e.match_source = tb_src[s]; e.match_source_any = tb_sany[s];
        e.match_tag = tb_tag[s]; e.match_tag_any = tb_tany[s];
        e.message_size = tb_total[s]; e.received_size = tb_recv[s];
    endfunction

    function automatic t_reply predict_lookup(t_request r);
        t_reply e;
        int s;
        logic [24:0] sum;
        logic [35:0] off;
        e = '0;
        e.status = ST_NOT_FOUND;
        case (r.mode)
            MODE_PUSH, MODE_POST: begin
                s = oldest_match(r, r.mode == MODE_PUSH);
                if (s < 0) begin
                    s = free_entry();
                    if (s < 0) begin
                        e.status = ST_FULL;
                        return e;
                    end
                    if (r.mode == MODE_PUSH) store_entry(s, r, 24'(r.fragment_size), 1'b0);
                    else store_entry(s, r, '0, 1'b1);
                end else if (r.mode == MODE_PUSH) begin
                    e.user_buffer_held = tb_user[s];
                    tb_src[s] = r.source; tb_sany[s] = r.source_any;
                    tb_tag[s] = r.tag; tb_tany[s] = r.tag_any;
                    tb_total[s] = r.total_size;
                    sum = {1'b0, tb_recv[s]} + 25'(r.fragment_size);
                    tb_recv[s] = sum[24] ? MASK24 : sum[23:0];
                end else begin
                    e.user_buffer_held = tb_user[s];
                    e.copy_length = tb_recv[s];
                    tb_user[s] = 1'b1;
                end
                if (r.mode == MODE_PUSH) begin
                    off = 36'(r.part) * 36'(FRAG_BYTES_DEF);
                    e.write_offset = off > 36'(MASK24) ? MASK24 : off[23:0];
                    e.copy_length = 24'(r.fragment_size);
                end
                e.status = ST_OK;
                fill_match(e, s);
            end
            MODE_POP, MODE_PROBE, MODE_REMOVE: begin
                s = oldest_match(r, 1'b0);
                if (s < 0) return e;
                fill_match(e, s);
                e.user_buffer_held = tb_user[s];
                e.status = ST_OK;
                if (r.mode == MODE_POP) begin
                    if (r.buffer_size < tb_total[s]) begin
                        e.status = ST_TOO_SMALL;
                        e.received_size = '0;
                    end else if (!tb_user[s]) begin
                        e.copy_length = tb_recv[s];
                    end
                end else if (r.mode == MODE_PROBE && tb_recv[s] < tb_total[s]) begin
                    e.status = ST_INCOMPLETE;
                end
                if (r.mode != MODE_PROBE) drop_entry(s);
            end
            default: ;
        endcase
        return e;
    endfunction

    // driver: one beat per accepted start
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(start && !busy) && start) begin
                // holding the current beat
            end else if (pending_items.size() > 0 && !hold_off &&
                         $urandom_range(99) >= send_idle_pct) begin
                req_q <= pending_items.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
            if (start && !busy)
                expected_replies.insert(expected_replies.size(), predict_lookup(req_q));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_valid) begin
            if (expected_replies.size() == 0) begin
                $error("result beat with nothing expected");
                failed = 1;
            end else begin
                e = expected_replies.pop_front();
                if (got.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, got.status); failed = 1; end
                if (got.slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, got.slot); failed = 1; end
                if (got.write_offset !== e.write_offset) begin
                    $error("write_offset exp %0h got %0h", e.write_offset, got.write_offset);
                    failed = 1; end
                if (got.copy_length !== e.copy_length) begin
                    $error("copy_length exp %0h got %0h", e.copy_length, got.copy_length);
                    failed = 1; end
                if (got.user_buffer_held !== e.user_buffer_held) begin
                    $error("user_buffer_held exp %0b got %0b", e.user_buffer_held,
                           got.user_buffer_held); failed = 1; end
                if (got.match_source !== e.match_source) begin
                    $error("match_source exp %0d got %0d", e.match_source, got.match_source);
                    failed = 1; end
                if (got.match_source_any !== e.match_source_any) begin
                    $error("match_source_any exp %0b got %0b", e.match_source_any,
                           got.match_source_any); failed = 1; end
                if (got.match_tag !== e.match_tag) begin
                    $error("match_tag exp %0h got %0h", e.match_tag, got.match_tag);
                    failed = 1; end
                if (got.match_tag_any !== e.match_tag_any) begin
                    $error("match_tag_any exp %0b got %0b", e.match_tag_any, got.match_tag_any);
                    failed = 1; end
                if (got.message_size !== e.message_size) begin
                    $error("message_size exp %0h got %0h", e.message_size, got.message_size);
                    failed = 1; end
                if (got.received_size !== e.received_size) begin
                    $error("received_size exp %0h got %0h", e.received_size, got.received_size);
                    failed = 1; end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("message_match_table regression: fail");
            $finish;
        end
    end

    function automatic t_request make_item(t_mode m, int src, int tg);
        t_request r;
        r = '0;
        r.mode = m;
        r.source = 10'(src);
        r.tag = 16'(tg);
        r.fragment_size = 13'($urandom_range(4096));
        r.total_size = 24'($urandom_range(8192));
        r.part = 12'($urandom);
        r.buffer_size = 24'($urandom_range(9000));
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || start || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        t_request r;
        int src, tg;
        for (int i = 0; i < NSLOT; i++) tb_valid[i] = 0;
        tb_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every mode, wildcards, full table, too small, unused modes
        r = make_item(MODE_PUSH, 1023, 16'hFFFF);
        r.fragment_size = 13'd4096; r.total_size = 24'hFFFFFF; r.part = 12'hFFF;
        add_item(r);
        r.fragment_size = 13'h1FFF; r.part = 12'd0;
        add_item(r);
        r = make_item(MODE_PROBE, 0, 0); r.source_any = 1; r.tag_any = 1;
        add_item(r);
        r = make_item(MODE_POST, 5, 7); r.total_size = 24'd100;
        add_item(r);
        r = make_item(MODE_PUSH, 5, 7); r.fragment_size = 13'd0; r.total_size = 24'd0;
        add_item(r);
        r = make_item(MODE_POP, 5, 7); r.buffer_size = 24'd0;
        add_item(r);
        r = make_item(MODE_POP, 0, 0); r.source_any = 1; r.tag_any = 1;
        r.buffer_size = 24'hFFFFFF;
        add_item(r);
        r = make_item(MODE_REMOVE, 1, 1);
        add_item(r);
        for (int i = 0; i < 17; i++) begin
            r = make_item(MODE_PUSH, i, i); r.total_size = 24'd50000;
            add_item(r);
        end
        r = make_item(MODE_POST, 900, 900);
        add_item(r);
        r = make_item(MODE_REMOVE, 3, 0); r.tag_any = 1;
        add_item(r);
        for (int m = 5; m < 8; m++) begin
            r = make_item(MODE_PROBE, 0, 0); r.mode = 3'(m);
            add_item(r);
        end
        wait_drained();
        // empty the table between phases
        for (int i = 0; i < NSLOT; i++) begin
            r = make_item(MODE_REMOVE, 0, 0); r.source_any = 1; r.tag_any = 1;
            add_item(r);
        end
        wait_drained();

        // random phases, some with sender idling; the receiver cannot stall
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 59 : (ph == 3) ? 28 : 0;
            for (int n = 0; n < 160; n++) begin
                src = $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(3);
                tg = $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(3);
                r = make_item(t_mode'($urandom_range(4)), src, tg);
                if ($urandom_range(9) == 0) r.mode = 3'($urandom_range(7));
                r.source_any = ($urandom_range(7) == 0);
                r.tag_any = ($urandom_range(7) == 0);
                if ($urandom_range(15) == 0) r.fragment_size = 13'($urandom);
                if ($urandom_range(15) == 0) r.total_size = 24'($urandom);
                if ($urandom_range(15) == 0) r.buffer_size = 24'($urandom);
                add_item(r);
                // pause until every result is back
                if (n == 80) begin
                    while (pending_items.size() > 0) @(posedge i_clk);
                    hold_off = 1;
                    while (start || expected_replies.size() > 0) @(posedge i_clk);
                    repeat (3) @(posedge i_clk);
                    hold_off = 0;
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (!failed && expected_replies.size() == 0)
            $display("message_match_table regression: pass");
        else
            $display("message_match_table regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
